/* sv/rrqs_pkg.sv */
// Shared types and constants for the round-robin quantum scheduler.
package rrqs_pkg;

    localparam int JOB_COUNT_DEF  = 8;
    localparam int BURST_BITS_DEF = 16;

    localparam int IDX_W      = 3;
    localparam int BURST_IN_W = 16;
    localparam int QUANTUM_W  = 16;
    localparam int WAIT_W     = 20;
    localparam int TOTAL_W    = 22;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd4;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX     = {TOTAL_W{1'b1}};

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } t_req;

    typedef struct packed {
        logic               served_valid;
        logic [IDX_W-1:0]   served_job;
        logic               job_finished;
        logic               all_finished;
        logic [TOTAL_W-1:0] total_wait;
    } t_result;

endpackage

/* sv/rrqs_next_job.sv */
// Circular priority encoder: first unfinished job after the given one.
module rrqs_next_job
    import rrqs_pkg::*;
#(
    parameter int JOB_COUNT = JOB_COUNT_DEF,
    localparam int CUR_W    = $clog2(JOB_COUNT)
) (
    input  logic [CUR_W-1:0]     i_cur,
    input  logic [JOB_COUNT-1:0] i_done,
    output logic [CUR_W-1:0]     o_next
);

    logic [CUR_W:0]   w_sum;
    logic [CUR_W-1:0] w_slot;

    // Walk from the farthest candidate back so the nearest one wins; keep i_cur if none.
    always_comb begin
        o_next = i_cur;
        w_sum  = '0;
        w_slot = '0;
        for (int k = JOB_COUNT - 1; k >= 1; k--) begin
            w_sum = {1'b0, i_cur} + (CUR_W + 1)'(k);
            if (w_sum >= (CUR_W + 1)'(JOB_COUNT)) begin
                w_sum = w_sum - (CUR_W + 1)'(JOB_COUNT);
            end
            w_slot = w_sum[CUR_W-1:0];
            if (!i_done[w_slot]) begin
                o_next = w_slot;
            end
        end
    end

endmodule

/* sv/rrqs_core.sv */
// Job table and one-pass scheduler update for a single transaction.
module rrqs_core
    import rrqs_pkg::*;
#(
    parameter int JOB_COUNT  = JOB_COUNT_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_req                  i_req,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [BURST_IN_W-1:0] i_burst,
    input  logic [QUANTUM_W-1:0]  i_quantum,
    output t_result               o_res
);

    localparam int CUR_W  = $clog2(JOB_COUNT);
    localparam int CNT_W  = $clog2(JOB_COUNT + 1);
    localparam int RAW_W  = WAIT_W + CUR_W;
    localparam int SUM_W  = (RAW_W > TOTAL_W) ? RAW_W : TOTAL_W;

    logic [BURST_BITS-1:0] r_rem  [JOB_COUNT];
    logic [WAIT_W-1:0]     r_wait [JOB_COUNT];
    logic [JOB_COUNT-1:0]  r_done;
    logic [CUR_W-1:0]      r_cur;
    logic [QUANTUM_W-1:0]  r_q;
    logic [SUM_W-1:0]      r_sum;

    logic [JOB_COUNT-1:0]  n_done;
    logic [CUR_W-1:0]      n_cur;
    logic [QUANTUM_W-1:0]  n_q;
    logic [SUM_W-1:0]      n_sum;

    logic [BURST_BITS-1:0] w_burst;
    logic [CUR_W-1:0]      w_slot;
    logic                  w_load_ok;
    logic                  w_serve;
    logic                  w_load;
    logic                  w_all_done;
    logic [QUANTUM_W-1:0]  w_q_lim;
    logic [CUR_W-1:0]      w_skip_job;
    logic [CUR_W-1:0]      w_cur1;
    logic [QUANTUM_W-1:0]  w_q0;
    logic [QUANTUM_W-1:0]  w_q1;
    logic [BURST_BITS-1:0] w_rem;
    logic [BURST_BITS-1:0] w_rem_dec;
    logic                  w_fin;
    logic                  w_expire;
    logic [CUR_W-1:0]      w_move_job;
    logic [JOB_COUNT-1:0]  w_age;
    logic [CNT_W-1:0]      w_age_cnt;

    // Fit the incoming burst to the table width.
    always_comb begin
        w_burst = '0;
        for (int b = 0; b < BURST_BITS && b < BURST_IN_W; b++) begin
            w_burst[b] = i_burst[b];
        end
    end

    assign w_slot     = CUR_W'(i_idx);
    assign w_load_ok  = (32'(i_idx) < JOB_COUNT);
    assign w_all_done = &r_done;
    assign w_serve    = i_step && (i_req == REQ_TICK) && !w_all_done;
    assign w_load     = i_step && (i_req == REQ_LOAD) && w_load_ok;
    assign w_q_lim    = (i_quantum == '0) ? QUANTUM_W'(1) : i_quantum;

    rrqs_next_job #(.JOB_COUNT(JOB_COUNT)) u_skip (
        .i_cur  (r_cur),
        .i_done (r_done),
        .o_next (w_skip_job)
    );

    // Skip a current job that is already done, restarting the quantum.
    assign w_cur1    = r_done[r_cur] ? w_skip_job : r_cur;
    assign w_q0      = r_done[r_cur] ? '0 : r_q;
    assign w_q1      = (w_q0 != '1) ? w_q0 + QUANTUM_W'(1) : w_q0;
    assign w_rem     = r_rem[w_cur1];
    assign w_rem_dec = (w_rem != '0) ? w_rem - BURST_BITS'(1) : '0;
    assign w_fin     = (w_rem_dec == '0);
    assign w_expire  = (w_q1 >= w_q_lim);

    rrqs_next_job #(.JOB_COUNT(JOB_COUNT)) u_move (
        .i_cur  (w_cur1),
        .i_done (r_done),
        .o_next (w_move_job)
    );

    always_comb begin
        w_age_cnt = '0;
        for (int i = 0; i < JOB_COUNT; i++) begin
            w_age[i] = !r_done[i] && (CUR_W'(i) != w_cur1) && (r_wait[i] != '1);
            w_age_cnt = w_age_cnt + CNT_W'(w_age[i]);
        end
    end

    always_comb begin
        n_done = r_done;
        n_cur  = r_cur;
        n_q    = r_q;
        n_sum  = r_sum;
        if (w_serve) begin
            n_sum = r_sum + SUM_W'(w_age_cnt);
            if (w_fin) begin
                n_done[w_cur1] = 1'b1;
            end
            if (w_fin || w_expire) begin
                n_cur = w_move_job;
                n_q   = '0;
            end else begin
                n_cur = w_cur1;
                n_q   = w_q1;
            end
        end else if (w_load) begin
            n_sum          = r_sum - SUM_W'(r_wait[w_slot]);
            n_done[w_slot] = (w_burst == '0);
        end
    end

    always_comb begin
        o_res.served_valid = w_serve;
        o_res.served_job   = w_serve ? IDX_W'(w_cur1) : '0;
        o_res.job_finished = w_serve && w_fin;
        o_res.all_finished = &n_done;
        o_res.total_wait   = (n_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : n_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '1;
            r_cur  <= '0;
            r_q    <= '0;
            r_sum  <= '0;
            for (int i = 0; i < JOB_COUNT; i++) begin
                r_wait[i] <= '0;
            end
        end else if (i_step) begin
            r_done <= n_done;
            r_cur  <= n_cur;
            r_q    <= n_q;
            r_sum  <= n_sum;
            for (int i = 0; i < JOB_COUNT; i++) begin
                if (w_serve && w_age[i]) begin
                    r_wait[i] <= r_wait[i] + WAIT_W'(1);
                end else if (w_load && (w_slot == CUR_W'(i))) begin
                    r_wait[i] <= '0;
                end
            end
        end
    end

    // Burst counters are read only for unfinished jobs, which were always loaded.
    always_ff @(posedge i_clk) begin
        if (w_serve) begin
            r_rem[w_cur1] <= w_rem_dec;
        end else if (w_load) begin
            r_rem[w_slot] <= w_burst;
        end
    end

endmodule

/* sv/round_robin_quantum_scheduler.sv */
// Round-robin scheduler with a time quantum: input register, job table, result register.
//
// The block keeps a table of JOB_COUNT jobs. A load transaction (req_type 0) sets one job's
// remaining burst and clears its wait count; a zero burst marks the job done at once, and a
// slot at or beyond JOB_COUNT is ignored. A tick transaction (req_type 1) serves the current
// job for one unit and ages every other unfinished job by one; a current job that is already
// done is first skipped to the next unfinished job in circular order. When the served job
// finishes, or when it has run time_quantum ticks (0 acts as 1), service moves to the next
// unfinished job and the quantum restarts. Every transaction returns exactly one result with
// the served job, the finished flags and the saturated total wait. Throughput is one
// transaction per cycle while the result channel is not stalled. An accepted transaction
// sits in the input register until the result register is free; the single-pass table
// update then loads its result into the result register, where o_valid goes high.
// Each table update is one chain of two circular priority encoders, a burst decrement and a
// running wait sum kept in a register. Write time_quantum only while the block is idle.
module round_robin_quantum_scheduler
    import rrqs_pkg::*;
#(
    parameter int JOB_COUNT  = JOB_COUNT_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_req_type,
    input  logic [IDX_W-1:0]      i_job_index,
    input  logic [BURST_IN_W-1:0] i_burst_length,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_served_valid,
    output logic [IDX_W-1:0]      o_served_job,
    output logic                  o_job_finished,
    output logic                  o_all_finished,
    output logic [TOTAL_W-1:0]    o_total_wait,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [QUANTUM_W-1:0]  i_cfg_wr_data
);

    logic                  r_in_valid;
    t_req                  r_in_req;
    logic [IDX_W-1:0]      r_in_idx;
    logic [BURST_IN_W-1:0] r_in_burst;
    logic                  r_out_valid;
    t_result               r_result;
    logic [QUANTUM_W-1:0]  r_quantum;

    logic    w_advance;
    logic    w_step;
    t_result w_res;

    // Result register frees up when empty or taken; the input register drains into it.
    assign w_advance = !r_out_valid || i_ready;
    assign w_step    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (i_cfg_wr_en) begin
            r_quantum <= i_cfg_wr_data;
        end
    end

    // Input register: hold a transaction until the update stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_req   <= t_req'(i_req_type);
            r_in_idx   <= i_job_index;
            r_in_burst <= i_burst_length;
        end
    end

    rrqs_core #(
        .JOB_COUNT  (JOB_COUNT),
        .BURST_BITS (BURST_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_req     (r_in_req),
        .i_idx     (r_in_idx),
        .i_burst   (r_in_burst),
        .i_quantum (r_quantum),
        .o_res     (w_res)
    );

    // Result register: load on each table update, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_served_valid = r_result.served_valid;
    assign o_served_job   = r_result.served_job;
    assign o_job_finished = r_result.job_finished;
    assign o_all_finished = r_result.all_finished;
    assign o_total_wait   = r_result.total_wait;

    // Every update lands in the result register on the next edge.
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("update did not produce a result");

    // A tick that serves nothing only happens with every job done.
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_in_req == REQ_TICK) && !w_res.served_valid) |-> w_res.all_finished)
        else $error("idle tick with unfinished jobs");

    // A served job that did not finish is still pending.
    a_served_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.served_valid && !w_res.job_finished) |-> !w_res.all_finished)
        else $error("served job left pending but all finished");

    // Loading a nonzero burst into a real slot leaves work to do.
    a_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_in_req == REQ_LOAD) && (r_in_burst != '0) &&
         (32'(r_in_idx) < JOB_COUNT) && (BURST_BITS >= BURST_IN_W))
        |-> !w_res.all_finished)
        else $error("load of a nonzero burst reported all finished");

endmodule

/* tb/tb_round_robin_quantum_scheduler.sv */
// Self-checking testbench for the round-robin quantum scheduler.
`timescale 1ns / 100ps

module tb_round_robin_quantum_scheduler;
    import rrqs_pkg::*;

    localparam int JOBS           = JOB_COUNT_DEF;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;     // covers the result register latency with margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_ITEMS   = 600;   // total of the phase quotas, split evenly over PHASES
    localparam int PHASES         = 6;
    localparam int TICK_CAP       = 80;    // ticks per batch before giving up on long jobs
    localparam int DIRECTED_ROWS  = 24;
    localparam logic [QUANTUM_W-1:0] QUANTUM_MAX = '1;

    typedef struct {
        t_req                  req;
        logic [IDX_W-1:0]      idx;
        logic [BURST_IN_W-1:0] burst;
        bit                    has_golden;
        t_result               golden;
    } t_stim_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_HEAVY,
        RX_COIN
    } t_rx_mode;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_req_type;
    logic [IDX_W-1:0]      i_job_index;
    logic [BURST_IN_W-1:0] i_burst_length;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_served_valid;
    logic [IDX_W-1:0]      o_served_job;
    logic                  o_job_finished;
    logic                  o_all_finished;
    logic [TOTAL_W-1:0]    o_total_wait;
    logic                  i_cfg_wr_en;
    logic [QUANTUM_W-1:0]  i_cfg_wr_data;

    // Scheduler shadow state, advanced once per accepted transaction
    logic [BURST_IN_W-1:0] rem_ticks [JOBS];
    bit                    job_idle  [JOBS];
    logic [WAIT_W-1:0]     job_wait  [JOBS];
    logic [IDX_W-1:0]      cur_job;
    logic [QUANTUM_W-1:0]  slice_cnt;
    logic [QUANTUM_W-1:0]  quantum_cfg;

    // Results still owed by the block, oldest first
    t_result pending_results [$];

    int mismatch_cnt;
    int results_seen;
    int item_cnt;
    int load_cnt;
    int tick_cnt;
    int served_cnt;
    int finished_cnt;
    int settings_cnt;
    int peak_wait;
    int burst_left;
    int idle_cycles;

    t_result   seen_res;
    t_result   want_res;
    t_stim_row directed_rows [DIRECTED_ROWS];

    round_robin_quantum_scheduler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_job_index    (i_job_index),
        .i_burst_length (i_burst_length),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_served_valid (o_served_valid),
        .o_served_job   (o_served_job),
        .o_job_finished (o_job_finished),
        .o_all_finished (o_all_finished),
        .o_total_wait   (o_total_wait),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scheduler prediction
    // ------------------------------------------------------------------

    function automatic bit every_job_done();
        foreach (job_idle[i]) begin
            if (!job_idle[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Circular search for the next unfinished slot; keep the current one if none is found.
    function automatic logic [IDX_W-1:0] next_pending(input logic [IDX_W-1:0] from);
        int j;
        for (int k = 1; k <= JOBS; k++) begin
            j = (int'(from) + k) % JOBS;
            if (!job_idle[j]) return IDX_W'(j);
        end
        return from;
    endfunction

    // Age every unfinished job except the one in service; saturate each count.
    function automatic void age_pending(input logic [IDX_W-1:0] served);
        foreach (job_wait[i]) begin
            if (i != int'(served) && !job_idle[i] && job_wait[i] != '1)
                job_wait[i] = job_wait[i] + 1'b1;
        end
    endfunction

    function automatic logic [TOTAL_W-1:0] wait_total();
        int sum;
        sum = 0;
        foreach (job_wait[i]) begin
            sum += int'(job_wait[i]);
            if (sum > int'(TOTAL_MAX)) sum = int'(TOTAL_MAX);
        end
        return TOTAL_W'(sum);
    endfunction

    function automatic void clear_schedule();
        quantum_cfg = QUANTUM_RESET;
        foreach (rem_ticks[i]) begin
            rem_ticks[i] = '0;
            job_idle[i]  = 1'b1;
            job_wait[i]  = '0;
        end
        cur_job   = '0;
        slice_cnt = '0;
    endfunction

    // Apply one transaction to the shadow state and return the status it should report.
    function automatic t_result schedule_step(input t_req req, input logic [IDX_W-1:0] idx,
                                              input logic [BURST_IN_W-1:0] burst);
        t_result              res;
        logic [IDX_W-1:0]     cur;
        logic [QUANTUM_W-1:0] slice_lim;
        res = '0;
        if (req == REQ_LOAD) begin
            rem_ticks[idx] = burst;
            job_wait[idx]  = '0;
            job_idle[idx]  = (burst == '0);
        end else if (!every_job_done()) begin
            cur       = cur_job;
            slice_lim = (quantum_cfg == '0) ? QUANTUM_W'(1) : quantum_cfg;
            // skip a slot that already finished before serving anything
            if (job_idle[cur]) begin
                cur       = next_pending(cur);
                slice_cnt = '0;
            end
            res.served_valid = 1'b1;
            res.served_job   = cur;
            if (rem_ticks[cur] != '0) rem_ticks[cur] = rem_ticks[cur] - 1'b1;
            if (slice_cnt != '1) slice_cnt = slice_cnt + 1'b1;
            if (rem_ticks[cur] == '0) begin
                job_idle[cur]    = 1'b1;
                res.job_finished = 1'b1;
                slice_cnt        = '0;
                age_pending(cur);
                cur = next_pending(cur);
            end else begin
                age_pending(cur);
                if (slice_cnt >= slice_lim) begin
                    cur       = next_pending(cur);
                    slice_cnt = '0;
                end
            end
            cur_job = cur;
        end
        res.all_finished = every_job_done();
        res.total_wait   = wait_total();
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then record what it should produce.
    // Idle the channel between bursts of random length.
    task automatic send_item(input t_req req, input logic [IDX_W-1:0] idx,
                             input logic [BURST_IN_W-1:0] burst,
                             input bit has_golden, input t_result golden);
        t_result predicted;
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_job_index    <= idx;
        i_burst_length <= burst;
        do @(posedge i_clk); while (!o_ready);
        predicted = schedule_step(req, idx, burst);
        pending_results.push_back(has_golden ? golden : predicted);
        item_cnt++;
        if (req == REQ_LOAD) load_cnt++;
        else tick_cnt++;
        if (predicted.served_valid) served_cnt++;
        if (predicted.job_finished) finished_cnt++;
        if (int'(predicted.total_wait) > peak_wait) peak_wait = int'(predicted.total_wait);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Hold the input channel idle until every owed result has been returned.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= q;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        quantum_cfg = q;
        settings_cnt++;
    endtask

    // Mostly short bursts, with some zero, medium and full-range lengths.
    function automatic logic [BURST_IN_W-1:0] pick_burst();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return BURST_IN_W'($urandom_range(13, 300));
            2:       return BURST_IN_W'($urandom_range(0, 65535));
            default: return BURST_IN_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Load a batch of jobs, tick them to completion with the odd stray load mixed in,
    // and sometimes retire whatever is still running.
    task automatic run_job_batch(input bit force_pause);
        int n_ticks;
        repeat ($urandom_range(1, JOBS)) begin
            send_item(REQ_LOAD, IDX_W'($urandom_range(0, JOBS - 1)), pick_burst(), 1'b0, '0);
        end
        if (force_pause || $urandom_range(0, 5) == 0) drain_results();
        n_ticks = 0;
        while (!every_job_done() && n_ticks < TICK_CAP) begin
            if ($urandom_range(0, 11) == 0) begin
                send_item(REQ_LOAD, IDX_W'($urandom_range(0, JOBS - 1)), pick_burst(),
                          1'b0, '0);
            end else begin
                send_item(REQ_TICK, IDX_W'($urandom), BURST_IN_W'($urandom), 1'b0, '0);
                n_ticks++;
            end
        end
        repeat ($urandom_range(0, 2)) begin
            send_item(REQ_TICK, IDX_W'($urandom), BURST_IN_W'($urandom), 1'b0, '0);
        end
        if (!every_job_done() && $urandom_range(0, 1) == 1) begin
            foreach (job_idle[i]) begin
                if (!job_idle[i]) send_item(REQ_LOAD, IDX_W'(i), '0, 1'b0, '0);
            end
        end
    endtask

    // Directed rows; golden results are typed in only where they are obvious.
    initial begin
        directed_rows = '{
            // nothing loaded: a tick serves no one
            '{REQ_TICK, 3'd0, 16'd0,    1'b1, {1'b0, 3'd0, 1'b0, 1'b1, 22'd0}},
            // zero burst loads straight into the done state
            '{REQ_LOAD, 3'd7, 16'd0,    1'b1, {1'b0, 3'd0, 1'b0, 1'b1, 22'd0}},
            '{REQ_LOAD, 3'd0, 16'd1,    1'b1, {1'b0, 3'd0, 1'b0, 1'b0, 22'd0}},
            // lone job finishes on its only tick and service stays put
            '{REQ_TICK, 3'd0, 16'd0,    1'b1, {1'b1, 3'd0, 1'b1, 1'b1, 22'd0}},
            '{REQ_LOAD, 3'd7, 16'hFFFF, 1'b1, {1'b0, 3'd0, 1'b0, 1'b0, 22'd0}},
            '{REQ_LOAD, 3'd3, 16'd2,    1'b0, '0},
            // current slot already finished: skip ahead before serving
            '{REQ_TICK, 3'd5, 16'hA5A5, 1'b0, '0},
            '{REQ_TICK, 3'd2, 16'h5A5A, 1'b0, '0},
            // only the long job is left, so quantum expiry keeps it in service
            '{REQ_TICK, 3'd7, 16'hFFFF, 1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_LOAD, 3'd5, 16'd3,    1'b0, '0},
            '{REQ_LOAD, 3'd1, 16'd1,    1'b0, '0},
            // quantum runs out, then rotation wraps from 7 to 1 and on to 5
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            // retire the long job by reloading it empty
            '{REQ_LOAD, 3'd7, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0},
            '{REQ_TICK, 3'd0, 16'd0,    1'b0, '0}
        };
    end

    // Main stimulus: reset, directed rows, then one random phase per quantum setting.
    initial begin
        logic [QUANTUM_W-1:0] plan [PHASES];
        int                   phase_start;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_req_type     <= REQ_LOAD;
        i_job_index    <= '0;
        i_burst_length <= '0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        clear_schedule();
        burst_left = $urandom_range(1, 12);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows run with the reset quantum
        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].req, directed_rows[r].idx, directed_rows[r].burst,
                      directed_rows[r].has_golden, directed_rows[r].golden);
        end

        // smallest quantum, zero (treated as one), largest, then random ones
        plan[0] = QUANTUM_W'(1);
        plan[1] = '0;
        plan[2] = QUANTUM_MAX;
        plan[3] = QUANTUM_W'($urandom_range(2, 9));
        plan[4] = QUANTUM_W'($urandom_range(2, 9));
        plan[5] = QUANTUM_W'($urandom_range(10, 65534));
        for (int p = 0; p < PHASES; p++) begin
            set_quantum(plan[p]);
            phase_start = item_cnt;
            run_job_batch(1'b1);
            while (item_cnt - phase_start < RANDOM_ITEMS / PHASES) run_job_batch(1'b0);
        end

        // drop valid, collect the last results, and let the pipeline settle
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        $display("Covered %0d loads and %0d ticks under %0d quantum settings (0, 1 and %0d too)",
                 load_cnt, tick_cnt, settings_cnt, QUANTUM_MAX);
        $display("%0d ticks served a job, %0d jobs completed, peak total wait %0d",
                 served_cnt, finished_cnt, peak_wait);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Backpressure in segments: fully open, rare stalls, mostly stalled, or coin flips.
    initial begin
        t_rx_mode mode;
        int       seg_len;
        bit       rdy;
        i_ready <= 1'b0;
        forever begin
            mode    = t_rx_mode'($urandom_range(0, 3));
            seg_len = $urandom_range(8, 60);
            for (int k = 0; k < seg_len; k++) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_SPARSE: rdy = (k % 7) != 0;
                    RX_HEAVY:  rdy = (k % 4) == 3;
                    default:   rdy = $urandom_range(0, 1) == 1;
                endcase
                i_ready <= rdy;
            end
        end
    end

    // Compare every returned transaction with the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_res = {o_served_valid, o_served_job, o_job_finished, o_all_finished,
                        o_total_wait};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing owed: %p", results_seen, seen_res);
            end else begin
                want_res = pending_results.pop_front();
                if (seen_res.served_valid !== want_res.served_valid ||
                    seen_res.served_job   !== want_res.served_job   ||
                    seen_res.job_finished !== want_res.job_finished ||
                    seen_res.all_finished !== want_res.all_finished ||
                    seen_res.total_wait   !== want_res.total_wait) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT) begin
                        $display("result %0d expected served=%0b job=%0d fin=%0b all=%0b wait=%0d",
                                 results_seen, want_res.served_valid, want_res.served_job,
                                 want_res.job_finished, want_res.all_finished,
                                 want_res.total_wait);
                        $display("result %0d got      served=%0b job=%0d fin=%0b all=%0b wait=%0d",
                                 results_seen, seen_res.served_valid, seen_res.served_job,
                                 seen_res.job_finished, seen_res.all_finished,
                                 seen_res.total_wait);
                    end
                end
            end
        end
    end

    // Stop a hung run: count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
